[sv/olid_pkg.sv]
package olid_pkg;

  // default sizes of the element store
  localparam int DEPTH_DEF  = 256;
  localparam int ELEM_W_DEF = 32;

  // field widths of the request and result
  localparam int CMD_W     = 3;
  localparam int POS_W     = 9;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 9;

  // configuration register
  localparam int                CAP_W        = 9;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 9'd200;
  localparam int                ADDR_W       = 2;
  localparam int                DATA_W       = 32;
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;

  // cells per group in the first level of the read tree
  localparam int TREE_GRP = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_TAIL = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DEL_TAIL = 3'd3,
    CMD_DEL_HEAD = 3'd4,
    CMD_DEL_POS  = 3'd5,
    CMD_READ     = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_RD_GRP = 2'd1,
    S_RD_SUM = 2'd2,
    S_WAIT   = 2'd3
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]    count_after;
  } out_t;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

[sv/olid_cell.sv]
module olid_cell #(
  parameter int IDX = 0,
  parameter int W   = olid_pkg::ELEM_W_DEF,
  parameter int AW  = 8
) (
  input  logic                  clk,
  input  olid_pkg::cell_ctl_t   ctl,
  input  logic [AW-1:0]         slot,
  input  logic [W-1:0]          din,
  input  logic [W-1:0]          left,
  input  logic [W-1:0]          right,
  input  logic [AW-1:0]         rd_slot,
  output logic [W-1:0]          q,
  output logic [W-1:0]          sel
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  // insert: write at the slot, take the lower neighbor above it
  // delete: take the upper neighbor from the slot on
  always_comb begin
    q_nxt = q_r;
    if (ctl.ins) begin
      if (MY_IDX == slot) begin
        q_nxt = din;
      end else if (MY_IDX > slot) begin
        q_nxt = left;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= slot) begin
        q_nxt = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q   = q_r;
  // only the addressed cell drives the read tree
  assign sel = (MY_IDX == rd_slot) ? q_r : '0;

endmodule

[sv/olid_rd_tree.sv]
module olid_rd_tree #(
  parameter int DEPTH = olid_pkg::DEPTH_DEF,
  parameter int W     = olid_pkg::ELEM_W_DEF
) (
  input  logic         clk,
  input  logic [W-1:0] sel [DEPTH],
  output logic [W-1:0] dout
);

  localparam int G     = olid_pkg::TREE_GRP;
  localparam int NGRP  = (DEPTH + G - 1) / G;
  localparam int NPAD  = NGRP * G;

  logic [W-1:0] pad   [NPAD];
  logic [W-1:0] grp_nxt [NGRP];
  logic [W-1:0] grp_r   [NGRP];

  // pad the cell outputs to whole groups
  for (genvar i = 0; i < NPAD; i++) begin : g_pad
    if (i < DEPTH) begin : g_used
      assign pad[i] = sel[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  // first level: or within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < G; k++) begin
        grp_nxt[g] = grp_nxt[g] | pad[g*G + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  // second level: or across the registered groups
  always_comb begin
    dout = '0;
    for (int g = 0; g < NGRP; g++) begin
      dout = dout | grp_r[g];
    end
  end

endmodule

[sv/ordered_list_insert_delete.sv]
// ordered list with positional insert and delete, one element per cell
// insert, delete, failed and undefined commands: result goes to the pending result register,
// then to the output register once it is free; up to one such request per cycle while the output
// is taken; successful read: the registered two-level or tree picks the addressed cell, and its
// result goes on through the pending result register; no request is taken until it is loaded
// reset: count cleared, capacity 200; cell contents are not cleared
module ordered_list_insert_delete #(
  parameter int DEPTH         = olid_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = olid_pkg::ELEM_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  olid_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output olid_pkg::out_t                    out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [olid_pkg::ADDR_W-1:0]       paddr,
  input  logic [olid_pkg::DATA_W-1:0]       pwdata,
  output logic [olid_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int W   = ELEMENT_WIDTH;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LW  = ((CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W) + 1;

  olid_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [olid_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [AW-1:0]    rd_slot_r, rd_slot_nxt;
  olid_pkg::out_t   res_r, res_nxt;
  olid_pkg::out_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             acc;
  logic             out_free;
  logic             out_load;
  logic             rd_go;
  logic             ins_ok;
  logic             del_ok;
  logic [LW-1:0]    cnt_l;
  logic [LW-1:0]    lim_l;
  logic [LW-1:0]    pos_l;
  logic [LW-1:0]    posm1_l;
  logic [LW-1:0]    slot_l;
  logic             full;
  logic             empty;
  logic [1:0]       stat;

  olid_pkg::cell_ctl_t ctl;
  logic [AW-1:0]    slot;
  logic [W-1:0]     elem_in;
  logic [W-1:0]     cq   [DEPTH];
  logic [W-1:0]     csel [DEPTH];
  logic [W-1:0]     tree_dout;

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  // request decode against the current count and limit
  assign cnt_l   = LW'(count_r);
  assign lim_l   = (LW'(cap_r) < LW'(DEPTH)) ? LW'(cap_r) : LW'(DEPTH);
  assign pos_l   = LW'(in_data.position);
  assign posm1_l = pos_l - 1'b1;
  assign full    = cnt_l >= lim_l;
  assign empty   = count_r == '0;

  always_comb begin
    stat   = olid_pkg::ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rd_go  = 1'b0;
    slot_l = '0;
    case (in_data.command)
      olid_pkg::CMD_INS_TAIL: begin
        if (full) begin
          stat = olid_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
          slot_l = cnt_l;
        end
      end
      olid_pkg::CMD_INS_HEAD: begin
        if (full) begin
          stat = olid_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      olid_pkg::CMD_INS_POS: begin
        if (full) begin
          stat = olid_pkg::ST_FULL;
        end else if (pos_l == '0 || posm1_l > cnt_l) begin
          stat = olid_pkg::ST_RANGE;
        end else begin
          ins_ok = 1'b1;
          slot_l = posm1_l;
        end
      end
      olid_pkg::CMD_DEL_TAIL: begin
        if (empty) begin
          stat = olid_pkg::ST_EMPTY;
        end else begin
          del_ok = 1'b1;
          slot_l = cnt_l - 1'b1;
        end
      end
      olid_pkg::CMD_DEL_HEAD: begin
        if (empty) begin
          stat = olid_pkg::ST_EMPTY;
        end else begin
          del_ok = 1'b1;
        end
      end
      olid_pkg::CMD_DEL_POS: begin
        if (empty) begin
          stat = olid_pkg::ST_EMPTY;
        end else if (pos_l == '0 || posm1_l >= cnt_l) begin
          stat = olid_pkg::ST_RANGE;
        end else begin
          del_ok = 1'b1;
          slot_l = posm1_l;
        end
      end
      olid_pkg::CMD_READ: begin
        if (empty) begin
          stat = olid_pkg::ST_EMPTY;
        end else if (pos_l == '0 || pos_l > cnt_l) begin
          stat = olid_pkg::ST_RANGE;
        end else begin
          rd_go  = 1'b1;
          slot_l = posm1_l;
        end
      end
      default: begin
        stat = olid_pkg::ST_OK;
      end
    endcase
  end

  // broadcast to the cell row
  assign ctl.ins = acc && ins_ok;
  assign ctl.del = acc && del_ok;
  assign slot    = slot_l[AW-1:0];
  assign elem_in = W'($signed(in_data.value));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] lft;
    logic [W-1:0] rgt;
    if (i == 0) begin : g_first
      assign lft = '0;
    end else begin : g_lower
      assign lft = cq[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_upper
      assign rgt = cq[i+1];
    end
    olid_cell #(
      .IDX (i),
      .W   (W),
      .AW  (AW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .slot    (slot),
      .din     (elem_in),
      .left    (lft),
      .right   (rgt),
      .rd_slot (rd_slot_r),
      .q       (cq[i]),
      .sel     (csel[i])
    );
  end

  // read select tree
  olid_rd_tree #(
    .DEPTH (DEPTH),
    .W     (W)
  ) u_rd_tree (
    .clk  (clk),
    .sel  (csel),
    .dout (tree_dout)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olid_pkg::S_IDLE: begin
        if (acc) begin
          state_nxt = rd_go ? olid_pkg::S_RD_GRP : olid_pkg::S_WAIT;
        end
      end
      olid_pkg::S_RD_GRP: begin
        state_nxt = olid_pkg::S_RD_SUM;
      end
      olid_pkg::S_RD_SUM: begin
        state_nxt = olid_pkg::S_WAIT;
      end
      olid_pkg::S_WAIT: begin
        if (out_free) begin
          if (acc) begin
            state_nxt = rd_go ? olid_pkg::S_RD_GRP : olid_pkg::S_WAIT;
          end else begin
            state_nxt = olid_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = olid_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      olid_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      olid_pkg::S_WAIT: begin
        in_ready = out_free;
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // count, pending result and read slot
  always_comb begin
    count_nxt   = count_r;
    rd_slot_nxt = rd_slot_r;
    res_nxt     = res_r;
    if (acc) begin
      if (ins_ok) begin
        count_nxt = count_r + 1'b1;
      end else if (del_ok) begin
        count_nxt = count_r - 1'b1;
      end
      rd_slot_nxt         = slot;
      res_nxt.status      = stat;
      res_nxt.read_value  = '0;
      res_nxt.count_after = olid_pkg::CNT_OUT_W'(count_nxt);
    end else if (state_r == olid_pkg::S_RD_SUM) begin
      res_nxt.read_value = olid_pkg::VAL_W'($signed(tree_dout));
    end
  end

  // output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // capacity register
  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && paddr == olid_pkg::REG_CAPACITY) begin
      cap_nxt = pwdata[olid_pkg::CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == olid_pkg::REG_CAPACITY) ? olid_pkg::DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olid_pkg::S_IDLE;
      count_r     <= '0;
      cap_r       <= olid_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_slot_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // the list never holds more than the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= LW'(DEPTH))
    else $error("element count above store depth");

  // the count moves only with a taken request
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r))
    else $error("element count changed without a request");

  // a successful insert grows the list by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ins_ok |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the list");

  // a successful read leaves the count alone and reaches the tree summing state
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    acc && rd_go |=> ##1 state_r == olid_pkg::S_RD_SUM && $stable(count_r))
    else $error("read did not follow the select tree path");
`endif

endmodule

[verif/ordered_list_insert_delete_tb.sv]
`timescale 1ns / 1ps

module ordered_list_insert_delete_tb;
  import olid_pkg::*;

  // command code outside the defined set, the block must leave the list alone
  localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int N_PHASES = 7;

  // mirror of the list: applies each accepted request and queues its outcome
  class list_scoreboard;
    logic signed [VAL_W-1:0] cells [DEPTH_DEF];
    int unsigned count;
    int unsigned capacity;
    out_t due_outcomes[$];
    int errors;
    int checked;

    function new();
      count = 0;
      capacity = 32'(CAP_RESET);
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned limit();
      return (capacity < DEPTH_DEF) ? capacity : DEPTH_DEF;
    endfunction

    task report(string msg);
      $display("[%0t] error: %s", $realtime, msg);
      errors++;
    endtask

    function status_t insert_at(int unsigned slot, logic signed [VAL_W-1:0] v);
      if (count >= limit()) return ST_FULL;
      if (slot > count) return ST_RANGE;
      for (int unsigned i = count; i > slot; i--) cells[i] = cells[i-1];
      cells[slot] = v;
      count++;
      return ST_OK;
    endfunction

    function status_t delete_at(int unsigned slot);
      if (count == 0) return ST_EMPTY;
      if (slot >= count) return ST_RANGE;
      for (int unsigned i = slot; i + 1 < count; i++) cells[i] = cells[i+1];
      count--;
      return ST_OK;
    endfunction

    // work out the outcome of one accepted request
    task apply_list_command(in_t req);
      out_t res;
      int unsigned pos;
      pos = 32'(req.position);
      res = '0;
      case (req.command)
        CMD_INS_TAIL: res.status = insert_at(count, req.value);
        CMD_INS_HEAD: res.status = insert_at(0, req.value);
        CMD_INS_POS: begin
          if (pos == 0 && count < limit()) res.status = ST_RANGE;
          else res.status = insert_at((pos == 0) ? 0 : pos - 1, req.value);
        end
        CMD_DEL_TAIL: res.status = delete_at((count == 0) ? 0 : count - 1);
        CMD_DEL_HEAD: res.status = delete_at(0);
        CMD_DEL_POS: begin
          if (pos == 0 && count != 0) res.status = ST_RANGE;
          else res.status = delete_at((pos == 0) ? 0 : pos - 1);
        end
        CMD_READ: begin
          if (count == 0) res.status = ST_EMPTY;
          else if (pos == 0 || pos > count) res.status = ST_RANGE;
          else begin
            res.status = ST_OK;
            res.read_value = cells[pos-1];
          end
        end
        default: res.status = ST_OK;
      endcase
      res.count_after = CNT_OUT_W'(count);
      due_outcomes.push_back(res);
    endtask

    // compare one accepted result with the oldest outcome waiting
    task check_result(out_t got);
      out_t want;
      if (due_outcomes.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = due_outcomes.pop_front();
      checked++;
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.read_value !== want.read_value)
        report($sformatf("read_value got %0h want %0h", got.read_value, want.read_value));
      if (got.count_after !== want.count_after)
        report($sformatf("count_after got %0d want %0d", got.count_after, want.count_after));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  list_scoreboard sb;
  int in_idle_pct = 23;
  int out_idle_pct = 54;
  int items_sent = 0;

  int unsigned phase_cap [N_PHASES] = '{256, 0, 511, 40, 5, 1, 200};
  int phase_len [N_PHASES] = '{300, 60, 350, 150, 130, 100, 210};
  int phase_ins [N_PHASES] = '{90, 50, 10, 50, 45, 45, 55};

  ordered_list_insert_delete u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic in_t mk(logic [CMD_W-1:0] cmd, int unsigned pos, logic [VAL_W-1:0] v);
    in_t r;
    r.command = cmd;
    r.position = POS_W'(pos);
    r.value = v;
    return r;
  endfunction

  // random request, mostly with positions that the list accepts
  function automatic in_t make_request(int ins_pct);
    in_t r;
    int pick;
    int unsigned cnt;
    int unsigned hi;
    cnt = sb.count;
    pick = $urandom_range(99);
    r.value = $urandom();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: r.value = 32'h8000_0000;
        1: r.value = 32'h7fff_ffff;
        2: r.value = '0;
        default: r.value = '1;
      endcase
    end
    r.position = POS_W'($urandom_range(511));
    if (pick < ins_pct) begin
      case ($urandom_range(2))
        0: r.command = CMD_INS_TAIL;
        1: r.command = CMD_INS_HEAD;
        default: r.command = CMD_INS_POS;
      endcase
    end else if (pick < 97) begin
      case ($urandom_range(4))
        0: r.command = CMD_DEL_TAIL;
        1: r.command = CMD_DEL_HEAD;
        2: r.command = CMD_DEL_POS;
        default: r.command = CMD_READ;
      endcase
    end else begin
      r.command = CMD_NONE;
    end
    if (r.command == CMD_INS_POS || r.command == CMD_DEL_POS || r.command == CMD_READ) begin
      hi = (r.command == CMD_INS_POS) ? cnt + 1 : cnt;
      if ($urandom_range(99) < 85) begin
        r.position = POS_W'($urandom_range((hi == 0) ? 1 : hi, 1));
      end else begin
        // boundary noise: position zero, just past the end, or left random
        case ($urandom_range(2))
          0: r.position = '0;
          1: r.position = POS_W'(hi + 1);
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  // offer one request, with random gaps before it
  task send_req(in_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.apply_list_command(req);
    items_sent++;
  endtask

  // stop offering and let every outstanding result arrive
  task settle_list();
    in_valid <= 1'b0;
    while (sb.due_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write capacity, then read it back
  task write_capacity(int unsigned cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_CAPACITY;
    pwdata <= cap;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.capacity = cap;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(cap))
      sb.report($sformatf("capacity read back %0d want %0d", prdata, cap));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // watchdog on accepted traffic
  initial begin : watchdog
    int stall;
    stall = 0;
    do begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
      else stall++;
    end while (stall < STALL_LIMIT);
    $display("[%0t] no traffic for %0d cycles", $realtime, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int ph;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, full and bad positions on a list of three
    write_capacity(3);
    send_req(mk(CMD_DEL_TAIL, 0, 0));
    send_req(mk(CMD_READ, 1, 0));
    send_req(mk(CMD_DEL_HEAD, 0, 0));
    send_req(mk(CMD_DEL_POS, 1, 0));
    send_req(mk(CMD_INS_POS, 0, 32'h1234_5678));
    send_req(mk(CMD_INS_POS, 2, 32'h1234_5678));
    send_req(mk(CMD_INS_TAIL, 0, 32'h7fff_ffff));
    send_req(mk(CMD_INS_HEAD, 511, 32'h8000_0000));
    send_req(mk(CMD_INS_POS, 2, 32'hffff_ffff));
    send_req(mk(CMD_INS_TAIL, 0, 32'h0));
    send_req(mk(CMD_INS_HEAD, 0, 32'h5a5a_a5a5));
    send_req(mk(CMD_INS_POS, 0, 32'h1));
    send_req(mk(CMD_READ, 0, 0));
    send_req(mk(CMD_READ, 4, 0));
    send_req(mk(CMD_READ, 511, 32'hffff_ffff));
    send_req(mk(CMD_READ, 1, 0));
    send_req(mk(CMD_READ, 2, 0));
    send_req(mk(CMD_READ, 3, 0));
    send_req(mk(CMD_NONE, 5, 32'h5555_5555));
    send_req(mk(CMD_DEL_POS, 0, 0));
    send_req(mk(CMD_DEL_POS, 4, 0));
    send_req(mk(CMD_DEL_POS, 2, 0));
    send_req(mk(CMD_DEL_HEAD, 0, 0));
    send_req(mk(CMD_DEL_TAIL, 0, 0));
    send_req(mk(CMD_DEL_TAIL, 0, 0));
    settle_list();

    // random phases, each with its own capacity and one of three idle patterns
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 2) begin
        in_idle_pct = 23;
        out_idle_pct = 54;
      end else if (ph < 4) begin
        in_idle_pct = 54;
        out_idle_pct = 23;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      write_capacity(phase_cap[ph]);
      repeat (phase_len[ph]) send_req(make_request(phase_ins[ph]));
      settle_list();
    end

    if (sb.due_outcomes.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.due_outcomes.size()));
    $display("run covered %0d requests and %0d checked results", items_sent, sb.checked);
    $display("over %0d capacity settings, from zero to 511, list filled and drained",
             N_PHASES + 1);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[ordered_list_insert_delete.f]
sv/olid_pkg.sv
sv/olid_cell.sv
sv/olid_rd_tree.sv
sv/ordered_list_insert_delete.sv
verif/ordered_list_insert_delete_tb.sv
